FILE: rtl/core/watched_precondition_applicability_core_assert.svh
// Assertion macros used by the core's datapath.
`ifndef WATCHED_PRECONDITION_APPLICABILITY_CORE_ASSERT_SVH
`define WATCHED_PRECONDITION_APPLICABILITY_CORE_ASSERT_SVH
// Antecedent holds, consequent must hold in the same cycle.
`define WPA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Antecedent holds, consequent must hold in the next cycle.
`define WPA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: rtl/core/wpa_pkg.sv
// Shared constants, codes and controller/datapath types of the applicability core.
package wpa_pkg;
	localparam int MaxOps = 64;
	localparam int OpW = 7;
	localparam int IdxW = 6;
	localparam int VarW = 6;
	localparam int DomW = 3;
	localparam int MaxPre = 8;
	localparam int PreW = 4;
	localparam int SlotW = 3;
	localparam int FactW = VarW + DomW;
	localparam int NumFacts = 512;
	localparam int ClrW = 10;
	localparam int NumVarW = 7;
	localparam logic [OpW-1:0] EmptyLink = 7'd64;
	localparam logic [NumVarW-1:0] MaxVarsW = 7'd64;
	localparam logic [PreW-1:0] MaxPreW = 4'd8;

	typedef enum logic [1:0] {
		MODE_ADD = 2'd0,
		MODE_CLOSE = 2'd1,
		MODE_SET = 2'd2,
		MODE_GEN = 2'd3
	} mode_t;

	typedef enum logic [17:0] {
		ST_CLEAR = 18'h00001,
		ST_IDLE = 18'h00002,
		ST_L_RD = 18'h00004,
		ST_C_RD = 18'h00008,
		ST_G_VAR = 18'h00010,
		ST_G_FACT = 18'h00020,
		ST_G_HEAD = 18'h00040,
		ST_G_OP = 18'h00080,
		ST_G_OPRD = 18'h00100,
		ST_G_K = 18'h00200,
		ST_G_KRD = 18'h00400,
		ST_G_KCMP = 18'h00800,
		ST_EMIT = 18'h01000,
		ST_A0 = 18'h02000,
		ST_A1 = 18'h04000,
		ST_U_CHK = 18'h08000,
		ST_U_RD = 18'h10000,
		ST_FIN = 18'h20000
	} state_t;

	typedef struct packed {
		state_t act;
		logic take;
	} cmd_t;

	typedef struct packed {
		mode_t in_mode;
		logic closed_full;
		logic cnt_full;
		logic cnt_zero;
		logic var_done;
		logic op_end;
		logic k_done;
		logic mismatch;
		logic out_busy;
		logic clr_done;
		logic u_done;
		logic gen;
		logic u_phase;
	} stat_t;
endpackage

FILE: rtl/core/watched_precondition_applicability_core.sv
// A load puts the fact in the open operator's next slot; a close files the operator on its first
// precondition's watch list unless the core is full or it has none. A generation walks each
// variable's watch list, refiling a woken operator on its first mismatch and emitting it on a
// full match, then emits each closed operator with no preconditions; output stalls hold it.
// Reset: asynchronous, active low; afterwards a clear pass empties all 512 watch-list entries
// before the first beat is taken. Configuration writes are taken at any time.
module watched_precondition_applicability_core (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic s_tvalid,
	output logic s_tready,
	// mode[1:0], var_index[7:2], var_value[10:8], zero fill
	input logic [15:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// op_index[5:0], none_applicable[6], overflow[7]
	output logic [7:0] m_tdata,
	output logic m_tlast
);
	import wpa_pkg::*;

	logic [NumVarW-1:0] num_vars_q;
	cmd_t cmd;
	stat_t st;

	assign pready = 1'b1;
	assign prdata = (paddr == 3'd0) ? {25'd0, num_vars_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) num_vars_q <= MaxVarsW;
		else if (psel && penable && pwrite && paddr == 3'd0) num_vars_q <= pwdata[NumVarW-1:0];
	end

	wpa_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.st(st),
		.s_tready(s_tready),
		.cmd(cmd)
	);

	wpa_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.s_tdata(s_tdata),
		.num_vars(num_vars_q),
		.m_tready(m_tready),
		.st(st),
		.m_tvalid(m_tvalid),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);
endmodule

FILE: rtl/core/wpa_ctrl.sv
// Controller state machine that sequences loads, list appends and generation.
module wpa_ctrl (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input wpa_pkg::stat_t st,
	output logic s_tready,
	output wpa_pkg::cmd_t cmd
);
	import wpa_pkg::*;

	state_t state_q, state_d;

	assign s_tready = (state_q == ST_IDLE);
	assign cmd.act = state_q;
	assign cmd.take = s_tready && s_tvalid;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (st.clr_done) state_d = ST_IDLE;
			ST_IDLE: begin
				if (cmd.take) begin
					case (st.in_mode)
						MODE_ADD: state_d = ST_L_RD;
						MODE_CLOSE: state_d = ST_C_RD;
						MODE_GEN: state_d = ST_G_VAR;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_L_RD: state_d = ST_IDLE;
			ST_C_RD: state_d = (st.closed_full || st.cnt_zero) ? ST_IDLE : ST_A0;
			ST_G_VAR: state_d = st.var_done ? ST_U_CHK : ST_G_FACT;
			ST_G_FACT: state_d = ST_G_HEAD;
			ST_G_HEAD: state_d = ST_G_OP;
			ST_G_OP: state_d = st.op_end ? ST_G_VAR : ST_G_OPRD;
			ST_G_OPRD: state_d = ST_G_K;
			ST_G_K: state_d = st.k_done ? ST_EMIT : ST_G_KRD;
			ST_G_KRD: state_d = ST_G_KCMP;
			ST_G_KCMP: state_d = st.mismatch ? ST_A0 : ST_G_K;
			ST_EMIT: begin
				if (!st.out_busy) state_d = st.u_phase ? ST_U_CHK : ST_A0;
			end
			ST_A0: state_d = ST_A1;
			ST_A1: state_d = st.gen ? ST_G_OP : ST_IDLE;
			ST_U_CHK: state_d = st.u_done ? ST_FIN : ST_U_RD;
			ST_U_RD: state_d = st.cnt_zero ? ST_EMIT : ST_U_CHK;
			ST_FIN: if (!st.out_busy) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end
endmodule

FILE: rtl/core/wpa_dp.sv
// Datapath: precondition store, counts, state values, watch lists and result register.
`include "watched_precondition_applicability_core_assert.svh"
module wpa_dp (
	input logic clk,
	input logic arst_n,
	input wpa_pkg::cmd_t cmd,
	input logic [15:0] s_tdata,
	input logic [wpa_pkg::NumVarW-1:0] num_vars,
	input logic m_tready,
	output wpa_pkg::stat_t st,
	output logic m_tvalid,
	output logic [7:0] m_tdata,
	output logic m_tlast
);
	import wpa_pkg::*;

	logic [FactW-1:0] store_mem [NumFacts];
	logic [PreW-1:0] cnt_mem [MaxOps];
	logic [MaxOps-1:0] cnt_vld_q;
	logic [DomW-1:0] sv_mem [MaxOps];
	logic [MaxOps-1:0] sv_vld_q;
	logic [2*OpW-1:0] ht_mem [NumFacts];
	logic [OpW-1:0] nxt_mem [MaxOps];

	logic [FactW-1:0] store_rd_q;
	logic [PreW-1:0] cnt_rd_q;
	logic [DomW-1:0] sv_rd_q;
	logic [2*OpW-1:0] ht_rd_q;
	logic [OpW-1:0] nxt_rd_q;

	logic [VarW-1:0] in_var_q;
	logic [DomW-1:0] in_val_q;
	logic [OpW-1:0] closed_q, op_q, nxt_q, var_q, uidx_q;
	logic [PreW-1:0] k_q, cnt_q;
	logic [FactW-1:0] fact_q, tgt_q, f_q;
	logic [ClrW-1:0] clr_q;
	logic ovf_q, gen_q, uph_q, pend_vld_q;
	logic [IdxW-1:0] pend_q;
	logic out_vld_q, out_last_q, out_none_q, out_ovf_q;
	logic [IdxW-1:0] out_idx_q;

	logic [IdxW-1:0] cnt_ra, sv_ra, nxt_ra;
	logic [FactW-1:0] store_ra, ht_ra, ht_wa;
	logic [2*OpW-1:0] ht_wd;
	logic ht_we, nxt_we, push, push_last;
	logic [IdxW-1:0] nxt_wa;
	logic [OpW-1:0] nxt_wd, ht_head, ht_tail;
	logic [NumVarW-1:0] limit;
	logic [IdxW-1:0] cand;
	mode_t in_mode;

	assign in_mode = mode_t'(s_tdata[1:0]);
	assign ht_head = ht_rd_q[2*OpW-1:OpW];
	assign ht_tail = ht_rd_q[OpW-1:0];
	assign limit = (num_vars < MaxVarsW) ? num_vars : MaxVarsW;
	assign cand = uph_q ? uidx_q[IdxW-1:0] : op_q[IdxW-1:0];

	assign st.in_mode = in_mode;
	assign st.closed_full = closed_q[OpW-1];
	assign st.cnt_full = (cnt_rd_q >= MaxPreW);
	assign st.cnt_zero = (cnt_rd_q == '0);
	assign st.var_done = (var_q >= limit);
	assign st.op_end = op_q[OpW-1];
	assign st.k_done = (k_q >= cnt_q);
	assign st.mismatch = (sv_rd_q != f_q[DomW-1:0]);
	assign st.out_busy = out_vld_q && !m_tready;
	assign st.clr_done = (clr_q == ClrW'(NumFacts - 1));
	assign st.u_done = (uidx_q >= closed_q);
	assign st.gen = gen_q;
	assign st.u_phase = uph_q;

	// Read addresses follow the controller step.
	always_comb begin
		cnt_ra = closed_q[IdxW-1:0];
		if (cmd.act == ST_G_OP) cnt_ra = op_q[IdxW-1:0];
		else if (cmd.act == ST_U_CHK) cnt_ra = uidx_q[IdxW-1:0];
		sv_ra = (cmd.act == ST_G_KRD) ? store_rd_q[FactW-1:DomW] : var_q[VarW-1:0];
		store_ra = (cmd.act == ST_G_K) ? {op_q[IdxW-1:0], k_q[SlotW-1:0]}
			: {closed_q[IdxW-1:0], {SlotW{1'b0}}};
		ht_ra = (cmd.act == ST_A0) ? tgt_q : {var_q[VarW-1:0], sv_rd_q};
		nxt_ra = op_q[IdxW-1:0];
	end

	// Watch-list head/tail and link writes.
	always_comb begin
		ht_we = 1'b0;
		ht_wa = tgt_q;
		ht_wd = {EmptyLink, EmptyLink};
		nxt_we = 1'b0;
		nxt_wa = op_q[IdxW-1:0];
		nxt_wd = EmptyLink;
		case (cmd.act)
			ST_CLEAR: begin
				ht_we = 1'b1;
				ht_wa = clr_q[FactW-1:0];
			end
			ST_G_HEAD: begin
				ht_we = 1'b1;
				ht_wa = fact_q;
			end
			ST_A0: nxt_we = 1'b1;
			ST_A1: begin
				ht_we = 1'b1;
				if (ht_head == EmptyLink) begin
					ht_wd = {op_q, op_q};
				end else begin
					ht_wd = {ht_head, op_q};
					nxt_we = 1'b1;
					nxt_wa = ht_tail[IdxW-1:0];
					nxt_wd = op_q;
				end
			end
			default: ht_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		store_rd_q <= store_mem[store_ra];
		if (cmd.act == ST_L_RD && !st.closed_full && !st.cnt_full)
			store_mem[{closed_q[IdxW-1:0], cnt_rd_q[SlotW-1:0]}] <= {in_var_q, in_val_q};
	end

	always_ff @(posedge clk) begin
		cnt_rd_q <= cnt_vld_q[cnt_ra] ? cnt_mem[cnt_ra] : '0;
		if (cmd.act == ST_L_RD && !st.closed_full && !st.cnt_full)
			cnt_mem[closed_q[IdxW-1:0]] <= cnt_rd_q + PreW'(1);
	end

	always_ff @(posedge clk) begin
		sv_rd_q <= sv_vld_q[sv_ra] ? sv_mem[sv_ra] : '0;
		if (cmd.take && in_mode == MODE_SET) sv_mem[s_tdata[7:2]] <= s_tdata[10:8];
	end

	always_ff @(posedge clk) begin
		ht_rd_q <= ht_mem[ht_ra];
		if (ht_we) ht_mem[ht_wa] <= ht_wd;
	end

	always_ff @(posedge clk) begin
		nxt_rd_q <= nxt_mem[nxt_ra];
		if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q <= '0;
			sv_vld_q <= '0;
		end else begin
			if (cmd.act == ST_L_RD && !st.closed_full && !st.cnt_full)
				cnt_vld_q[closed_q[IdxW-1:0]] <= 1'b1;
			if (cmd.take && in_mode == MODE_SET) sv_vld_q[s_tdata[7:2]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			in_var_q <= s_tdata[7:2];
			in_val_q <= s_tdata[10:8];
		end
		case (cmd.act)
			ST_C_RD: begin
				op_q <= closed_q;
				tgt_q <= store_rd_q;
			end
			ST_G_FACT: fact_q <= {var_q[VarW-1:0], sv_rd_q};
			ST_G_HEAD: op_q <= ht_head;
			ST_G_OP: k_q <= '0;
			ST_G_OPRD: begin
				nxt_q <= nxt_rd_q;
				cnt_q <= cnt_rd_q;
			end
			ST_G_K: if (st.k_done) tgt_q <= fact_q;
			ST_G_KRD: f_q <= store_rd_q;
			ST_G_KCMP: begin
				if (st.mismatch) tgt_q <= f_q;
				else k_q <= k_q + PreW'(1);
			end
			ST_A1: if (gen_q) op_q <= nxt_q;
			default: k_q <= k_q;
		endcase
	end

	assign push = (cmd.act == ST_EMIT && !st.out_busy && pend_vld_q)
		|| (cmd.act == ST_FIN && !st.out_busy);
	assign push_last = (cmd.act == ST_FIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			closed_q <= '0;
			ovf_q <= 1'b0;
			gen_q <= 1'b0;
			uph_q <= 1'b0;
			pend_vld_q <= 1'b0;
			var_q <= '0;
			uidx_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.act == ST_CLEAR) clr_q <= clr_q + ClrW'(1);
			if (cmd.take) begin
				gen_q <= (in_mode == MODE_GEN);
				uph_q <= 1'b0;
				var_q <= '0;
				pend_vld_q <= 1'b0;
			end
			if (cmd.act == ST_L_RD && (st.closed_full || st.cnt_full)) ovf_q <= 1'b1;
			if (cmd.act == ST_C_RD) begin
				if (st.closed_full) ovf_q <= 1'b1;
				else closed_q <= closed_q + OpW'(1);
			end
			if (cmd.act == ST_G_VAR && st.var_done) begin
				uph_q <= 1'b1;
				uidx_q <= '0;
			end
			if (cmd.act == ST_G_OP && st.op_end) var_q <= var_q + OpW'(1);
			if (cmd.act == ST_U_RD && !st.cnt_zero) uidx_q <= uidx_q + OpW'(1);
			if (cmd.act == ST_EMIT && !st.out_busy) begin
				pend_vld_q <= 1'b1;
				pend_q <= cand;
				if (uph_q) uidx_q <= uidx_q + OpW'(1);
			end
			if (cmd.act == ST_FIN && !st.out_busy) begin
				pend_vld_q <= 1'b0;
				gen_q <= 1'b0;
			end
			if (push) out_vld_q <= 1'b1;
			else if (m_tready) out_vld_q <= 1'b0;
		end
	end

	// The held-back beat goes out once the next one is known; the final beat carries tlast.
	always_ff @(posedge clk) begin
		if (push) begin
			out_idx_q <= (push_last && !pend_vld_q) ? '0 : pend_q;
			out_none_q <= push_last && !pend_vld_q;
			out_last_q <= push_last;
			out_ovf_q <= ovf_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = {out_ovf_q, out_none_q, out_idx_q};
	assign m_tlast = out_last_q;

	`WPA_ASSERT_IMP(a_closed_rng, 1'b1, closed_q <= OpW'(MaxOps), "operator count past capacity")
	`WPA_ASSERT_IMP(a_pend_idle, cmd.act == ST_IDLE || cmd.act == ST_CLEAR, !pend_vld_q, "result held while idle")
	`WPA_ASSERT_IMP(a_scan_rng, cmd.act == ST_G_OP, var_q < OpW'(MaxOps), "variable scan past range")
	`WPA_ASSERT_NXT(a_push_busy, push, out_vld_q, "pushed beat not shown")
endmodule
